>>> rtl/core/kvp_pkg.sv
`default_nettype none

package kvp_pkg;

	localparam int MAX_LENGTH_BYTES = 4;
	localparam int NUMBER_BYTES     = 8;
	localparam int COUNT_WIDTH      = 16;

	localparam int LEN_W     = 28;
	localparam int LCNT_W    = $clog2(MAX_LENGTH_BYTES + 1);
	localparam int VSEEN_W   = $clog2(NUMBER_BYTES + 1);
	localparam int NUM_W     = 64;
	localparam int KLEN_W    = 7;
	localparam int IDX_W     = 16;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [KLEN_W-1:0] MAX_KEY_RESET = 7'd32;

	// byte_kind codes
	localparam logic [2:0] KIND_LEN     = 3'd0;
	localparam logic [2:0] KIND_HDR     = 3'd1;
	localparam logic [2:0] KIND_KEY     = 3'd2;
	localparam logic [2:0] KIND_VAL     = 3'd3;
	localparam logic [2:0] KIND_IGNORED = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_LEN_OVER  = 3'd1;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd2;
	localparam logic [2:0] ST_SHORT     = 3'd3;
	localparam logic [2:0] ST_KEY_LONG  = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	typedef enum logic [4:0] {
		PH_LEN    = 5'b00001,
		PH_HDR    = 5'b00010,
		PH_KEY    = 5'b00100,
		PH_VAL    = 5'b01000,
		PH_SILENT = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic [2:0]        byte_kind;
		logic [IDX_W-1:0]  record_index;
		logic              string_key;
		logic [KLEN_W-1:0] key_length;
		logic [LEN_W-1:0]  rec_length;
		logic [NUM_W-1:0]  key_number;
		logic [NUM_W-1:0]  value_number;
		logic              record_end;
		logic [2:0]        status;
		logic              buffer_end;
		logic [IDX_W-1:0]  record_count;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/kv_record_stream_parser.sv
// Key-value record stream parser.
// Input channel: in_valid / in_stall with data_byte and last_byte, one byte of
// the record buffer per transaction; last_byte marks the final byte.
// Output channel: out_valid / out_stall, one result transaction per input byte:
// echo, byte kind, record index, key header fields, decoded length, numeric key
// and value, record end, status, buffer end and record count.
// Config channel: cfg_valid / cfg_ready with cfg_data (max_key_length); always ready.
// The user must write it only while the block is idle; the block does not enforce it.
// A byte's result is registered in the result register, or in the skid entry
// while a result waits. Throughput: one byte per cycle while in_stall is low;
// the parse state and the result are computed combinationally from the byte.
// A one-entry skid register behind the result register lets a byte be taken
// while a result waits; in_stall rises only when that skid entry is occupied,
// and the held result is not changed while out_stall is high.
// Reset clears all parse state and both result entries and sets max_key_length
// to 32. After a format error the block marks bytes as ignored until the buffer
// ends; the byte with last_byte always returns the parse state to reset.
`default_nettype none

module kv_record_stream_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       last_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [7:0]                      out_byte,
	output logic [2:0]                      byte_kind,
	output logic [kvp_pkg::IDX_W-1:0]       record_index,
	output logic                            string_key,
	output logic [kvp_pkg::KLEN_W-1:0]      key_length,
	output logic [kvp_pkg::LEN_W-1:0]       rec_length,
	output logic [kvp_pkg::NUM_W-1:0]       key_number,
	output logic [kvp_pkg::NUM_W-1:0]       value_number,
	output logic                            record_end,
	output logic [2:0]                      status,
	output logic                            buffer_end,
	output logic [kvp_pkg::IDX_W-1:0]       record_count,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [kvp_pkg::KLEN_W-1:0] cfg_data
);
	import kvp_pkg::*;

	logic [KLEN_W-1:0]      max_key_q;

	phase_t                 phase_q, phase_n;
	logic [LEN_W-1:0]       len_q, len_n;
	logic [LCNT_W-1:0]      lcnt_q, lcnt_n;
	logic [LEN_W-1:0]       pay_q, pay_n;
	logic [KLEN_W-1:0]      kleft_q, kleft_n;
	logic [KLEN_W-1:0]      klen_q, klen_n;
	logic                   kstr_q, kstr_n;
	logic [NUM_W-1:0]       knum_q, knum_n;
	logic [NUM_W-1:0]       vnum_q, vnum_n;
	logic [VSEEN_W-1:0]     vseen_q, vseen_n;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;

	result_t                res;
	result_t                out_q, skid_q;
	logic                   out_valid_q, skid_valid_q;
	logic                   accept, out_pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign out_pop   = out_valid_q && !out_stall;

	always_comb begin
		logic [2:0]             kind;
		logic [2:0]             st;
		logic                   rend;
		logic [COUNT_WIDTH-1:0] cnt_upd;

		phase_n = phase_q;
		len_n   = len_q;
		lcnt_n  = lcnt_q;
		pay_n   = pay_q;
		kleft_n = kleft_q;
		klen_n  = klen_q;
		kstr_n  = kstr_q;
		knum_n  = knum_q;
		vnum_n  = vnum_q;
		vseen_n = vseen_q;
		cnt_n   = cnt_q;
		kind    = KIND_IGNORED;
		st      = ST_OK;

		unique case (phase_q)
			PH_LEN: begin
				kind = KIND_LEN;
				if (lcnt_q >= LCNT_W'(MAX_LENGTH_BYTES)) begin
					st = ST_LEN_OVER;
				end else begin
					lcnt_n = lcnt_q + 1'b1;
					if (len_q > (LEN_MAX >> 7))
						len_n = LEN_MAX;
					else
						len_n = {len_q[LEN_W-8:0], data_byte[6:0]};
					if (!data_byte[7]) begin
						if (len_n == '0)
							st = ST_ZERO_LEN;
						else if ((LEN_W+1)'(lcnt_n) + (LEN_W+1)'(len_n) <= (LEN_W+1)'(2))
							st = ST_SHORT;
						else begin
							pay_n   = len_n;
							phase_n = PH_HDR;
						end
					end
				end
			end
			PH_HDR: begin
				kind   = KIND_HDR;
				kstr_n = data_byte[7];
				klen_n = data_byte[6:0];
				if (data_byte[6:0] > max_key_q ||
				    LEN_W'(data_byte[6:0]) + LEN_W'(1) > pay_q) begin
					st = ST_KEY_LONG;
				end else begin
					pay_n   = pay_q - 1'b1;
					kleft_n = data_byte[6:0];
					phase_n = (data_byte[6:0] != '0) ? PH_KEY : PH_VAL;
				end
			end
			PH_KEY: begin
				kind = KIND_KEY;
				// only the leading bytes of a numeric key are kept
				if (!kstr_q && (klen_q - kleft_q) < KLEN_W'(NUMBER_BYTES))
					knum_n = {knum_q[NUM_W-9:0], data_byte};
				kleft_n = kleft_q - 1'b1;
				pay_n   = pay_q - 1'b1;
				if (kleft_n == '0)
					phase_n = PH_VAL;
			end
			PH_VAL: begin
				kind = KIND_VAL;
				if (vseen_q < VSEEN_W'(NUMBER_BYTES)) begin
					vnum_n  = {vnum_q[NUM_W-9:0], data_byte};
					vseen_n = vseen_q + 1'b1;
				end
				pay_n = pay_q - 1'b1;
			end
			PH_SILENT: begin
				kind = KIND_IGNORED;
			end
			default: begin
				kind = KIND_IGNORED;
			end
		endcase

		rend = (st == ST_OK) && (phase_n == PH_KEY || phase_n == PH_VAL) && (pay_n == '0);
		if (st == ST_OK && last_byte && !rend && kind != KIND_IGNORED)
			st = ST_TRUNC;

		cnt_upd = (rend && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

		res.out_byte     = data_byte;
		res.byte_kind    = kind;
		res.record_index = IDX_W'(cnt_q);
		res.string_key   = kstr_n;
		res.key_length   = klen_n;
		res.rec_length   = len_n;
		res.key_number   = kstr_n ? '0 : knum_n;
		res.value_number = vnum_n;
		res.record_end   = rend;
		res.status       = st;
		res.buffer_end   = last_byte;
		res.record_count = last_byte ? IDX_W'(cnt_upd) : '0;

		if (rend || st != ST_OK) begin
			len_n   = '0;
			lcnt_n  = '0;
			pay_n   = '0;
			kleft_n = '0;
			klen_n  = '0;
			kstr_n  = 1'b0;
			knum_n  = '0;
			vnum_n  = '0;
			vseen_n = '0;
			cnt_n   = cnt_upd;
			phase_n = (st != ST_OK) ? PH_SILENT : PH_LEN;
		end
		if (last_byte) begin
			phase_n = PH_LEN;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_key_q <= MAX_KEY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_key_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			len_q   <= '0;
			lcnt_q  <= '0;
			pay_q   <= '0;
			kleft_q <= '0;
			klen_q  <= '0;
			kstr_q  <= 1'b0;
			knum_q  <= '0;
			vnum_q  <= '0;
			vseen_q <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			lcnt_q  <= lcnt_n;
			pay_q   <= pay_n;
			kleft_q <= kleft_n;
			klen_q  <= klen_n;
			kstr_q  <= kstr_n;
			knum_q  <= knum_n;
			vnum_q  <= vnum_n;
			vseen_q <= vseen_n;
			cnt_q   <= cnt_n;
		end
	end

	// result register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || out_pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_valid_q || out_pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_q.out_byte;
	assign byte_kind    = out_q.byte_kind;
	assign record_index = out_q.record_index;
	assign string_key   = out_q.string_key;
	assign key_length   = out_q.key_length;
	assign rec_length   = out_q.rec_length;
	assign key_number   = out_q.key_number;
	assign value_number = out_q.value_number;
	assign record_end   = out_q.record_end;
	assign status       = out_q.status;
	assign buffer_end   = out_q.buffer_end;
	assign record_count = out_q.record_count;

endmodule

`default_nettype wire
